// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// Each macro expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen on a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/core/bbd_pkg.sv -----
package bbd_pkg;

	// fixed field and queue sizes
	localparam int DATA_W     = 64;
	localparam int QUEUE_BITS = 128;
	localparam int CNT_W      = 8;
	localparam int NEED_W     = 7;

	// request kinds on the input tuser
	localparam logic REQ_SOURCE = 1'b0;
	localparam logic REQ_MASK   = 1'b1;

	// result status codes on the output tuser
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;

	// queue update request from the control stage
	typedef struct packed {
		logic              append;
		logic              drop;
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  drop_cnt;
	} q_op_t;

	// deposit unit result
	typedef struct packed {
		logic [DATA_W-1:0] word;
		logic [CNT_W-1:0]  used;
		logic              underflow;
	} dep_res_t;

endpackage

// ----- rtl/core/bbd_deposit.sv -----
module bbd_deposit import bbd_pkg::*; (
	input  logic [DATA_W-1:0] mask,
	input  logic [DATA_W-1:0] q_lo,
	input  logic [CNT_W-1:0]  q_cnt,
	output dep_res_t          res
);

	logic [5:0]        rank [DATA_W];
	logic [DATA_W-1:0] dep;
	logic [NEED_W-1:0] need;

	// rank of each mask bit = number of ones below it; pick that queue bit.
	// Queue bits at and above the fill count are zero, so underflowed
	// positions come out zero on their own.
	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			rank[i] = 6'($countones(mask & ((64'd1 << i) - 64'd1)));
			dep[i]  = mask[i] & q_lo[rank[i]];
		end
	end

	// bits consumed, clipped to what is queued
	always_comb begin
		need          = NEED_W'($countones(mask));
		res.word      = dep;
		res.underflow = {1'b0, need} > q_cnt;
		res.used      = res.underflow ? q_cnt : {1'b0, need};
	end

endmodule

// ----- rtl/core/bbd_queue.sv -----
module bbd_queue import bbd_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  q_op_t                 op,
	output logic [QUEUE_BITS-1:0] bits,
	output logic [CNT_W-1:0]      cnt,
	output logic                  full
);

	localparam logic [CNT_W-1:0] WordInc = CNT_W'(WORD_BITS);

	logic [QUEUE_BITS-1:0] bits_q, bits_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;

	// next queue contents: drop consumed bits or append a source word
	always_comb begin
		bits_d = bits_q;
		cnt_d  = cnt_q;
		if (op.drop) begin
			bits_d = bits_q >> op.drop_cnt;
			cnt_d  = cnt_q - op.drop_cnt;
		end else if (op.append) begin
			bits_d = bits_q | ({{(QUEUE_BITS-DATA_W){1'b0}}, op.word} << cnt_q);
			cnt_d  = cnt_q + WordInc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			cnt_q  <= '0;
		end else begin
			bits_q <= bits_d;
			cnt_q  <= cnt_d;
		end
	end

	// no room for another full word
	assign full = ({1'b0, cnt_q} + (CNT_W+1)'(WORD_BITS)) > (CNT_W+1)'(QUEUE_BITS);
	assign bits = bits_q;
	assign cnt  = cnt_q;

endmodule

// ----- rtl/core/buffered_bit_deposit_stream.sv -----
// Buffered bit deposit stream: expands packed bits under mask words.
// Input words (s_axis): tuser[0] selects the kind. A source word appends
// its low WORD_BITS bits to a 128-bit pending queue; a mask word takes the
// next popcount(mask) queued bits and deposits them, lowest first, at the
// mask's one positions. Each mask word yields one output word (m_axis);
// a source word yields one only when the queue has no room for it, in which
// case it is dropped and reported as overflow with zero data.
// Status on m_axis_tuser: ok, underflow (too few bits queued, the queue is
// emptied), overflow (source word dropped).
// An accepted word is registered in the input stage and evaluated there; its result
// is registered in the output register that drives m_axis. Throughput: one word
// per cycle unless a word with a result meets a full output register that the
// receiver stalls; the queue update of one word is complete before the next is
// evaluated, so words may follow back to back. Reset empties the queue and both
// stages. When the receiver stalls, the result is held in the output register and
// one more word waits in the input stage; source words that produce no result keep draining.
module buffered_bit_deposit_stream import bbd_pkg::*; #(
	parameter int WORD_BITS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [DATA_W-1:0] s_axis_tdata,  // [63:0] data_word
	input  logic              s_axis_tuser,  // [0] req_type
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [DATA_W-1:0] m_axis_tdata,  // [63:0] deposited_word
	output logic [1:0]        m_axis_tuser   // [1:0] status
);

	localparam logic [DATA_W-1:0] WordMask = {DATA_W{1'b1}} >> (DATA_W - WORD_BITS);

	logic              valid_s1;
	logic              type_s1;
	logic [DATA_W-1:0] data_s1;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [1:0]        out_status_q;

	logic [DATA_W-1:0]     masked;
	logic                  is_mask;
	logic                  produces;
	logic                  advance;
	q_op_t                 q_op;
	dep_res_t              dep;
	logic [QUEUE_BITS-1:0] q_bits;
	logic [CNT_W-1:0]      q_cnt;
	logic                  q_full;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			type_s1 <= s_axis_tuser;
			data_s1 <= s_axis_tdata;
		end
	end

	// stage control: a word leaves s1 unless its result cannot be stored
	always_comb begin
		masked        = data_s1 & WordMask;
		is_mask       = (type_s1 == REQ_MASK);
		produces      = is_mask || q_full;
		advance       = valid_s1 && (!produces || !out_valid_q || m_axis_tready);
		s_axis_tready = !valid_s1 || advance;
		q_op.append   = advance && !is_mask && !q_full;
		q_op.drop     = advance && is_mask;
		q_op.word     = masked;
		q_op.drop_cnt = dep.used;
	end

	bbd_queue #(
		.WORD_BITS(WORD_BITS)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (q_op),
		.bits  (q_bits),
		.cnt   (q_cnt),
		.full  (q_full)
	);

	bbd_deposit u_deposit (
		.mask (masked),
		.q_lo (q_bits[DATA_W-1:0]),
		.q_cnt(q_cnt),
		.res  (dep)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produces) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produces) begin
			if (is_mask) begin
				out_data_q   <= dep.word;
				out_status_q <= dep.underflow ? ST_UNDERFLOW : ST_OK;
			end else begin
				out_data_q   <= '0;
				out_status_q <= ST_OVERFLOW;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

	// checks
	`include "assert_macros.svh"

	`ASSERT_NEVER(a_cnt_range, q_cnt > CNT_W'(QUEUE_BITS), "queue count above capacity")
	`ASSERT_CLK(a_tail_zero, (q_bits >> q_cnt) == '0, "queue bits above count not zero")
	`ASSERT_CLK(a_append_cnt, q_op.append |=> (q_cnt == $past(q_cnt) + CNT_W'(WORD_BITS)), "append count wrong")
	`ASSERT_CLK(a_underflow_empty, (q_op.drop && dep.underflow) |=> (q_cnt == '0), "underflow left bits queued")

endmodule

// ----- verif/tb_buffered_bit_deposit_stream.sv -----
// Tracks the pending bit queue of the block and the results it must return.
class deposit_scoreboard;
	typedef struct {
		logic [bbd_pkg::DATA_W-1:0] word;
		logic [1:0]                 status;
	} deposit_result_t;

	int                           word_bits;
	logic [bbd_pkg::QUEUE_BITS-1:0] queued_bits;
	int                           queued_cnt;
	deposit_result_t              expected_results[$];
	int                           errors;
	int                           words_seen;
	int                           results_checked;
	int                           underflows;
	int                           overflows;

	function new(int width);
		word_bits        = width;
		queued_bits      = '0;
		queued_cnt       = 0;
		errors           = 0;
		words_seen       = 0;
		results_checked  = 0;
		underflows       = 0;
		overflows        = 0;
	endfunction

	// Predict the effect of one accepted input word on the queue.
	function void note_word(logic kind, logic [bbd_pkg::DATA_W-1:0] data);
		logic [bbd_pkg::DATA_W-1:0] used_mask;
		logic [bbd_pkg::DATA_W-1:0] scattered;
		logic [bbd_pkg::QUEUE_BITS-1:0] widened;
		deposit_result_t            res;
		int                         need;
		int                         used;
		used_mask = (word_bits >= bbd_pkg::DATA_W) ? '1 : ((64'd1 << word_bits) - 64'd1);
		data      = data & used_mask;
		words_seen++;
		if (kind == bbd_pkg::REQ_SOURCE) begin
			if (queued_cnt + word_bits > bbd_pkg::QUEUE_BITS) begin
				// no room: word dropped, queue untouched
				res.word   = '0;
				res.status = bbd_pkg::ST_OVERFLOW;
				expected_results.push_back(res);
			end else begin
				widened     = {{(bbd_pkg::QUEUE_BITS-bbd_pkg::DATA_W){1'b0}}, data};
				queued_bits = queued_bits | (widened << queued_cnt);
				queued_cnt  = queued_cnt + word_bits;
			end
		end else begin
			// deposit oldest queued bits at the mask's ones, lowest first
			scattered = '0;
			need      = 0;
			used      = 0;
			for (int i = 0; i < word_bits; i++) begin
				if (data[i]) begin
					need++;
					if (used < queued_cnt) begin
						scattered[i] = queued_bits[used];
						used++;
					end
				end
			end
			queued_bits = queued_bits >> used;
			queued_cnt  = queued_cnt - used;
			res.word    = scattered;
			res.status  = (need > used) ? bbd_pkg::ST_UNDERFLOW : bbd_pkg::ST_OK;
			expected_results.push_back(res);
		end
	endfunction

	// Compare one accepted output word with the oldest prediction.
	function void check_word(logic [bbd_pkg::DATA_W-1:0] data, logic [1:0] status);
		deposit_result_t exp_res;
		if (status == bbd_pkg::ST_UNDERFLOW) underflows++;
		if (status == bbd_pkg::ST_OVERFLOW) overflows++;
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected output word: expected none, actual data %h status %0d",
				$time, data, status);
			errors++;
			return;
		end
		exp_res = expected_results.pop_front();
		results_checked++;
		if (data !== exp_res.word) begin
			$display("%0t: deposited word mismatch: expected %h, actual %h",
				$time, exp_res.word, data);
			errors++;
		end
		if (status !== exp_res.status) begin
			$display("%0t: status mismatch: expected %0d, actual %0d",
				$time, exp_res.status, status);
			errors++;
		end
	endfunction
endclass

module tb_buffered_bit_deposit_stream;
	import bbd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WORD_BITS   = 64;
	localparam int HOLD_CYCLES = 60;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [DATA_W-1:0] s_axis_tdata;   // [63:0] data_word
	logic              s_axis_tuser;   // [0] req_type
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [DATA_W-1:0] m_axis_tdata;   // [63:0] deposited_word
	logic [1:0]        m_axis_tuser;   // [1:0] status

	deposit_scoreboard sb;
	int                idle_pct;
	int                src_pct;
	logic              hold_req;

	buffered_bit_deposit_stream #(
		.WORD_BITS(WORD_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// overall time limit
	initial begin
		#2ms;
		$display("tb_buffered_bit_deposit_stream: errors");
		$finish;
	end

	function automatic logic [DATA_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// masks of varied density, so both full deposits and underflows occur
	function automatic logic [DATA_W-1:0] rand_mask();
		logic [DATA_W-1:0] m;
		case ($urandom_range(0, 7))
			0: m = '0;
			1: m = '1;
			2: m = 64'd1 << $urandom_range(0, DATA_W-1);
			3: m = rand_word() & rand_word() & rand_word();
			4: m = rand_word() | rand_word();
			default: m = rand_word();
		endcase
		return m;
	endfunction

	// Offer one word, wait for the handshake, then maybe idle a while.
	task automatic send_word(input logic kind, input logic [DATA_W-1:0] data);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= data;
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(kind, data);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		logic held;
		held = 1'b0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
				m_axis_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata, m_axis_tuser);
	end

	initial begin
		int waited;
		sb       = new(WORD_BITS);
		idle_pct = 30;
		src_pct  = 50;
		hold_req = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= REQ_SOURCE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty queue, full queue, exact fill, overflow, sparse/dense masks
		send_word(REQ_MASK, '1);                     // underflow on empty queue
		send_word(REQ_MASK, '0);                     // empty mask on empty queue
		send_word(REQ_MASK, 64'd1);                  // single-bit underflow
		send_word(REQ_SOURCE, '1);
		send_word(REQ_MASK, '0);                     // empty mask, bits waiting
		send_word(REQ_MASK, 64'h8000_0000_0000_0000);
		send_word(REQ_SOURCE, '0);
		send_word(REQ_SOURCE, 64'hA5A5_5A5A_0F0F_F0F0); // dropped, one bit short
		send_word(REQ_MASK, '1);
		send_word(REQ_MASK, '1);                     // underflow, queue emptied
		send_word(REQ_SOURCE, 64'h0123_4567_89AB_CDEF);
		send_word(REQ_SOURCE, 64'hFEDC_BA98_7654_3210); // queue exactly full
		send_word(REQ_SOURCE, '1);                   // dropped at full queue
		send_word(REQ_MASK, 64'h5555_5555_5555_5555);
		send_word(REQ_MASK, 64'hAAAA_AAAA_AAAA_AAAA);
		send_word(REQ_MASK, '1);
		send_word(REQ_MASK, '1);
		send_word(REQ_SOURCE, 64'h8000_0000_0000_0001);
		send_word(REQ_MASK, 64'hF000_0000_0000_000F);
		send_word(REQ_MASK, '1);

		// receiver holds off while masks keep coming, filling the output path
		idle_pct = 0;
		hold_req = 1'b1;
		send_word(REQ_SOURCE, rand_word());
		send_word(REQ_SOURCE, rand_word());
		for (int i = 0; i < 12; i++)
			send_word(REQ_MASK, rand_mask());

		// random segments with changing idle and source rates, last one calm
		for (int seg = 0; seg < 8; seg++) begin
			idle_pct = (seg == 7) ? 0 : (seg % 3 == 1) ? 0 : $urandom_range(10, 50);
			src_pct  = $urandom_range(30, 70);
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 99) < src_pct)
					send_word(REQ_SOURCE, ($urandom_range(0, 15) == 0) ? '1 : rand_word());
				else
					send_word(REQ_MASK, rand_mask());
			end
		end
		s_axis_tvalid <= 1'b0;

		// drain
		waited = 0;
		while (sb.expected_results.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (sb.expected_results.size() != 0) begin
			$display("%0t: %0d output words never arrived", $time, sb.expected_results.size());
			sb.errors += sb.expected_results.size();
		end

		$display("run covered %0d input words and %0d checked results", sb.words_seen,
			sb.results_checked);
		$display("seen %0d underflow and %0d overflow results", sb.underflows, sb.overflows);
		if (sb.errors == 0) begin
			$display("tb_buffered_bit_deposit_stream: clean");
		end else begin
			$display("tb_buffered_bit_deposit_stream: errors");
		end
		$finish;
	end
endmodule

// ----- buffered_bit_deposit_stream.f -----
+incdir+rtl/core
rtl/core/bbd_pkg.sv
rtl/core/bbd_deposit.sv
rtl/core/bbd_queue.sv
rtl/core/buffered_bit_deposit_stream.sv
verif/tb_buffered_bit_deposit_stream.sv
